// ===== src/cswg_pkg.sv =====
package cswg_pkg;

  localparam int MAX_LEN    = 4096;
  localparam int COS_DEPTH  = 1024;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_BITS  = 17;
  localparam int COS_BITS   = 17;
  localparam int TERMS      = 5;

  localparam int IDX_W      = 12;
  localparam int LEN_W      = 13;
  localparam int TYPE_W     = 3;
  localparam int VAL_W      = 18;
  localparam int COEF_W     = 18;
  localparam int COS_W      = COS_BITS + 1;
  localparam int SCOS_W     = COS_W + 1;
  localparam int PROD_W     = COEF_W + SCOS_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int PHASE_W    = $clog2(4 * COS_DEPTH);
  localparam int OFF_W      = $clog2(COS_DEPTH);
  localparam int ADDR_W     = OFF_W + 1;
  localparam int QUO_W      = IDX_W + 1;
  localparam int DIV_STAGES = QUO_W;
  localparam int SHIFT      = COEF_BITS + COS_BITS - FRAC_BITS;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;

  localparam logic [TYPE_W-1:0] TYPE_RESET = 3'd0;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 13'd64;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam logic signed [COEF_W-1:0] COEF_TAB [0:7][0:TERMS-1] = '{
    '{18'sd65536, -18'sd65536, 18'sd0,     18'sd0,     18'sd0},
    '{18'sd49152, -18'sd65536, 18'sd16384, 18'sd0,     18'sd0},
    '{18'sd40960, -18'sd61440, 18'sd24576, -18'sd4096, 18'sd0},
    '{18'sd35840, -18'sd57344, 18'sd28672, -18'sd8192, 18'sd1024},
    '{18'sd65536, -18'sd65536, 18'sd0,     18'sd0,     18'sd0},
    '{18'sd54757, -18'sd65536, 18'sd10779, 18'sd0,     18'sd0},
    '{18'sd43763, -18'sd62841, 18'sd21773, -18'sd2695, 18'sd0},
    '{18'sd37648, -18'sd58759, 18'sd27215, -18'sd6777, 18'sd672}
  };

  typedef logic [COS_W-1:0] cos_rom_t [0:COS_DEPTH];

  typedef struct packed {
    logic [TYPE_W-1:0] wtype;
    logic              clamped;
  } side_t;

  // truncating signed quotient by a positive divisor, shift and subtract
  function automatic longint div_trunc(longint num, longint dvs);
    longint a;
    longint q;
    logic   neg;
    neg = (num < 0);
    a = neg ? -num : num;
    q = 0;
    for (int b = 62; b >= 0; b--) begin
      if ((a >>> b) >= dvs) begin
        a = a - (dvs <<< b);
        q = q | (64'sd1 <<< b);
      end
    end
    return neg ? -q : q;
  endfunction

  // quarter-wave cosine in Q1.17 by integer Taylor series in Q30
  function automatic cos_rom_t cos_rom_build();
    cos_rom_t tab;
    longint x;
    longint x2;
    longint term;
    longint sum;
    for (int i = 0; i <= COS_DEPTH; i++) begin
      x = div_trunc(HALF_PI_Q30 * longint'(i) + longint'(COS_DEPTH / 2),
                    longint'(COS_DEPTH));
      x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
      term = 64'sd1 <<< 30;
      sum = term;
      for (int n = 1; n <= 13; n++) begin
        term = -div_trunc(term * x2, 64'sd1 <<< 30);
        term = div_trunc(term, longint'((2 * n - 1) * (2 * n)));
        sum = sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + (64'sd1 <<< 12)) >>> 13;
      tab[i] = sum[COS_W-1:0];
    end
    return tab;
  endfunction

  localparam cos_rom_t COS_ROM = cos_rom_build();

endpackage

// ===== src/cswg_div.sv =====
module cswg_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [cswg_pkg::IDX_W-1:0] in_k,
  input  cswg_pkg::side_t          in_side,
  input  logic [cswg_pkg::IDX_W-1:0] den,
  output logic                     out_valid,
  output logic [cswg_pkg::QUO_W-1:0] out_quo,
  output logic [cswg_pkg::IDX_W-1:0] out_rem,
  output cswg_pkg::side_t          out_side
);
  import cswg_pkg::*;

  // (k << 12) / den, one quotient bit per stage
  logic              vld [0:DIV_STAGES-1];
  logic [IDX_W-1:0]  rm  [0:DIV_STAGES-1];
  logic [QUO_W-1:0]  qt  [0:DIV_STAGES-1];
  side_t             sd  [0:DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    sd[0] <= in_side;
    if (in_k >= den) begin
      rm[0] <= in_k - den;
      qt[0] <= {1'b1, {(QUO_W-1){1'b0}}};
    end else begin
      rm[0] <= in_k;
      qt[0] <= '0;
    end
  end

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_stage
    logic [IDX_W:0] t;
    logic           ge;
    logic [IDX_W:0] diff;
    assign t    = {rm[s-1], 1'b0};
    assign ge   = t >= {1'b0, den};
    assign diff = t - {1'b0, den};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld[s-1];
      end
      sd[s] <= sd[s-1];
      rm[s] <= ge ? diff[IDX_W-1:0] : t[IDX_W-1:0];
      qt[s] <= qt[s-1] | (QUO_W'(ge) << (DIV_STAGES - 1 - s));
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_quo   = qt[DIV_STAGES-1];
  assign out_rem   = rm[DIV_STAGES-1];
  assign out_side  = sd[DIV_STAGES-1];

endmodule

// ===== src/cswg_cos_lane.sv =====
module cswg_cos_lane (
  input  logic                              clk,
  input  logic [cswg_pkg::PHASE_W-1:0]      phase,
  output logic signed [cswg_pkg::SCOS_W-1:0] cos_val
);
  import cswg_pkg::*;

  localparam cos_rom_t ROM = COS_ROM;

  logic [1:0]       quad;
  logic [OFF_W-1:0] off;
  logic [ADDR_W-1:0] addr;
  logic             neg;
  logic [ADDR_W-1:0] addr_q;
  logic             neg_q;
  logic             neg_qq;
  logic [COS_W-1:0] rd;

  assign quad = phase[PHASE_W-1:PHASE_W-2];
  assign off  = phase[OFF_W-1:0];

  always_comb begin
    unique case (quad)
      2'd0:    begin addr = {1'b0, off};                   neg = 1'b0; end
      2'd1:    begin addr = ADDR_W'(COS_DEPTH) - {1'b0, off}; neg = 1'b1; end
      2'd2:    begin addr = {1'b0, off};                   neg = 1'b1; end
      default: begin addr = ADDR_W'(COS_DEPTH) - {1'b0, off}; neg = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    addr_q <= addr;
    neg_q  <= neg;
    rd     <= ROM[addr_q];
    neg_qq <= neg_q;
  end

  assign cos_val = neg_qq ? -$signed({1'b0, rd}) : $signed({1'b0, rd});

endmodule

// ===== src/cosine_sum_window_generator_core.sv =====
// Rife-Vincent cosine-sum window generator (classes I and III, up to five terms).
// Request: drive sample_index with start high; it is taken at a clock edge where
// busy is low. busy is high only during reset, so one request may enter every cycle.
// Result: done pulses for one cycle with window_value (signed, 65536 = 1.0) and
// index_clamped (index above den, length minus one limited to 1..4095, replaced by den).
// The receiver cannot stall; results leave in request order.
// Throughput: one request per cycle. The pipeline holds an input stage, the
// 13-stage restoring divider for the phase (one quotient bit a stage), a phase
// stage, the registered quarter-wave ROM lanes, then multiply, sum and
// round/saturate stages.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 = window type,
// 1 = window length; cfg_ready is always high. Write only while no request is
// in flight. Reset sets type 0 (Hann) and length 64, and empties the pipeline.
module cosine_sum_window_generator_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [cswg_pkg::IDX_W-1:0]            sample_index,
  output logic                                  done,
  output logic signed [cswg_pkg::VAL_W-1:0]     window_value,
  output logic                                  index_clamped,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cswg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cswg_pkg::LEN_W-1:0]            cfg_data
);
  import cswg_pkg::*;

  localparam int NLANE = TERMS - 1;
  localparam int LANE_LAT = 2;

  logic [TYPE_W-1:0] window_type;
  logic [LEN_W-1:0]  window_length;
  logic [IDX_W-1:0]  den;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_type   <= TYPE_RESET;
      window_length <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WINDOW_TYPE) begin
        window_type <= cfg_data[TYPE_W-1:0];
      end else if (cfg_index == CFG_WINDOW_LENGTH) begin
        window_length <= cfg_data;
      end
    end
  end

  always_comb begin
    if (window_length < LEN_W'(2)) begin
      den = IDX_W'(1);
    end else if (window_length > LEN_W'(MAX_LEN)) begin
      den = IDX_W'(MAX_LEN - 1);
    end else begin
      den = IDX_W'(window_length - LEN_W'(1));
    end
  end

  // input stage
  logic             a_valid;
  logic [IDX_W-1:0] a_k;
  side_t            a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
    a_side.wtype <= window_type;
    if (sample_index > den) begin
      a_k <= den;
      a_side.clamped <= 1'b1;
    end else begin
      a_k <= sample_index;
      a_side.clamped <= 1'b0;
    end
  end

  logic             d_valid;
  logic [QUO_W-1:0] d_quo;
  logic [IDX_W-1:0] d_rem;
  side_t            d_side;

  cswg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_k      (a_k),
    .in_side   (a_side),
    .den       (den),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_rem   (d_rem),
    .out_side  (d_side)
  );

  // phase of term m: (m*q + round((2*m*r + den) / (2*den) part)) mod turn
  localparam int T_W = IDX_W + 3;
  logic [T_W-1:0]     thr [0:3];
  logic [PHASE_W-1:0] phase_next [0:NLANE-1];
  logic [PHASE_W-1:0] phase [0:NLANE-1];
  logic               b_valid;
  side_t              b_side;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      thr[j] = T_W'(2 * j + 1) * T_W'(den);
    end
  end

  for (genvar m = 0; m < NLANE; m++) begin : g_phase
    logic [QUO_W+2:0] mq;
    logic [T_W-1:0]   tr;
    logic [2:0]       cnt;
    assign mq  = (QUO_W+3)'(m + 1) * (QUO_W+3)'(d_quo);
    assign tr  = T_W'(2 * (m + 1)) * T_W'(d_rem);
    assign cnt = 3'(tr >= thr[0]) + 3'(tr >= thr[1]) + 3'(tr >= thr[2]) + 3'(tr >= thr[3]);
    assign phase_next[m] = mq[PHASE_W-1:0] + PHASE_W'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= d_valid;
    end
    b_side <= d_side;
    for (int m = 0; m < NLANE; m++) begin
      phase[m] <= phase_next[m];
    end
  end

  logic signed [SCOS_W-1:0] cosv [0:NLANE-1];

  for (genvar m = 0; m < NLANE; m++) begin : g_lane
    cswg_cos_lane u_lane (
      .clk     (clk),
      .phase   (phase[m]),
      .cos_val (cosv[m])
    );
  end

  logic  l_valid [0:LANE_LAT-1];
  side_t l_side  [0:LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        l_valid[i] <= 1'b0;
      end
    end else begin
      l_valid[0] <= b_valid;
      for (int i = 1; i < LANE_LAT; i++) begin
        l_valid[i] <= l_valid[i-1];
      end
    end
    l_side[0] <= b_side;
    for (int i = 1; i < LANE_LAT; i++) begin
      l_side[i] <= l_side[i-1];
    end
  end

  // multiply
  logic                     e_valid;
  logic                     e_clamped;
  logic signed [PROD_W-1:0] prod [0:NLANE-1];
  logic signed [COEF_W-1:0] e_c0;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= l_valid[LANE_LAT-1];
    end
    e_clamped <= l_side[LANE_LAT-1].clamped;
    e_c0 <= COEF_TAB[l_side[LANE_LAT-1].wtype][0];
    for (int m = 0; m < NLANE; m++) begin
      prod[m] <= COEF_TAB[l_side[LANE_LAT-1].wtype][m+1] * cosv[m];
    end
  end

  // sum
  logic                    f_valid;
  logic                    f_clamped;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;

  always_comb begin
    acc_next = ACC_W'(e_c0) <<< COS_BITS;
    for (int m = 0; m < NLANE; m++) begin
      acc_next = acc_next + ACC_W'(prod[m]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= e_valid;
    end
    f_clamped <= e_clamped;
    acc <= acc_next;
  end

  // round half up and saturate
  localparam int RV_W = ACC_W - SHIFT + 1;
  logic signed [ACC_W:0]  rsum;
  logic signed [RV_W-1:0] rval;
  logic signed [VAL_W-1:0] sat;

  assign rsum = (ACC_W+1)'(acc) + ((ACC_W+1)'(1) <<< (SHIFT - 1));
  assign rval = RV_W'(rsum >>> SHIFT);

  always_comb begin
    if (rval > RV_W'((1 <<< (VAL_W - 1)) - 1)) begin
      sat = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (rval < -(RV_W'(1) <<< (VAL_W - 1))) begin
      sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat = rval[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_valid;
    end
    window_value  <= sat;
    index_clamped <= f_clamped;
  end

  localparam int LAT = DIV_STAGES + LANE_LAT + 5;

  a_done_from_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a request");

  a_reset_flush: assert property (@(posedge clk)
    !rst && $past(rst) |-> !done)
    else $error("result right after reset");

  a_clamp_index: assert property (@(posedge clk) disable iff (rst)
    done && index_clamped |-> $past(sample_index, LAT) != '0)
    else $error("clamp flagged on index zero");

endmodule
